/* design/fblr_pkg.sv */
// Package: shared constants and command codes for the line/rect plotter.
package fblr_pkg;
    localparam int DefFrameWidth  = 320;
    localparam int DefFrameHeight = 240;
    localparam int CoordW = 12;
    localparam int ColorW = 4;
    localparam int CfgW   = 8;
    localparam int WorkW  = 16;

    localparam logic [1:0] FuncPlot = 2'd0;
    localparam logic [1:0] FuncLine = 2'd1;
    localparam logic [1:0] FuncRect = 2'd2;
    localparam logic [1:0] FuncRead = 2'd3;

    localparam logic RegBandTop    = 1'b0;
    localparam logic RegBandHeight = 1'b1;
endpackage

/* design/framebuffer_line_rect_plotter.sv */
// Top level: packed 4bpp frame store with point, line, rectangle and read commands.
//
// Usage: present func, ax, ay, bx, by, color with start high while busy is low;
// the request is taken at that edge. Exactly one result follows per request:
// read_color is valid for one cycle while done is high (0 for drawing commands).
// The receiver cannot stall; done is a single-cycle strobe.
// Configuration (band_top at index 0, band_height at 1) goes in through cfg_we/
// cfg_index/cfg_data; the user must write it only while idle (not enforced here).
// Each pixel is a read-modify-write of one frame store byte through a
// synchronous memory in three steps (address, read, write back); reads and
// pixels outside the frame or band skip the write. A point or read visits one
// pixel, a line max(|dx|,|dy|)+1, a rectangle clipped_w*clipped_h (none if empty).
// done pulses in the first idle cycle, so a new request can be taken at the
// same edge that takes the result. The memory port sets the rate.
// After reset the block clears the frame store one byte a cycle, all
// (FRAME_WIDTH+1)/2*FRAME_HEIGHT bytes (38400 by default), with busy high.
module framebuffer_line_rect_plotter #(
    parameter int FRAME_WIDTH  = fblr_pkg::DefFrameWidth,
    parameter int FRAME_HEIGHT = fblr_pkg::DefFrameHeight
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    output logic                                   done,
    input  logic                                   cfg_we,
    input  logic                                   cfg_index,
    input  logic [fblr_pkg::CfgW-1:0]              cfg_data,
    input  logic [1:0]                             func,
    input  logic signed [fblr_pkg::CoordW-1:0]     ax,
    input  logic signed [fblr_pkg::CoordW-1:0]     ay,
    input  logic signed [fblr_pkg::CoordW-1:0]     bx,
    input  logic signed [fblr_pkg::CoordW-1:0]     by,
    input  logic [fblr_pkg::ColorW-1:0]            color,
    output logic [fblr_pkg::ColorW-1:0]            read_color
);
    localparam int RowBytes = (FRAME_WIDTH + 1) / 2;
    localparam int Depth    = RowBytes * FRAME_HEIGHT;
    localparam int AW       = $clog2(Depth);
    localparam int W        = fblr_pkg::WorkW;
    localparam logic signed [W-1:0] One = W'(1);

    localparam logic [2:0] StClear = 3'd0;
    localparam logic [2:0] StIdle  = 3'd1;
    localparam logic [2:0] StSetup = 3'd2;
    localparam logic [2:0] StAddr  = 3'd3;
    localparam logic [2:0] StRead  = 3'd4;
    localparam logic [2:0] StWrite = 3'd5;
    localparam logic [2:0] StDone  = 3'd6;

    logic [7:0] mem [Depth];
    logic [7:0] rdata_reg;

    logic [2:0] state_reg, state_next;
    logic [AW-1:0] clr_reg;
    logic [fblr_pkg::CfgW-1:0] top_reg, hgt_reg;
    logic [1:0] func_reg;
    logic [fblr_pkg::ColorW-1:0] col_reg;
    logic signed [W-1:0] x_reg, y_reg, x0_reg, x1_reg, y1_reg;
    logic signed [W-1:0] p_reg, m_reg, maj2_reg, n_reg;
    logic sx_reg, sy_reg, xmaj_reg, skip_reg;
    logic [AW-1:0] addr_reg;
    logic hit_reg, done_reg;
    logic [fblr_pkg::ColorW-1:0] rc_reg;

    logic signed [W-1:0] dx, dy, adx, ady, bandhi, yhi, rx0, rx1, ry0, ry1;
    logic signed [W-1:0] axw, ayw, bxw, byw, p_step, topw;
    logic inband, inframe, pix_ok, last_pix, step_minor;

    assign axw = W'(ax);
    assign ayw = W'(ay);
    assign bxw = W'(bx);
    assign byw = W'(by);
    assign topw = W'({1'b0, top_reg});
    assign dx  = bxw - axw;
    assign dy  = byw - ayw;
    assign adx = dx[W-1] ? -dx : dx;
    assign ady = dy[W-1] ? -dy : dy;
    assign bandhi = topw + W'({1'b0, hgt_reg});
    assign yhi = (bandhi > W'(FRAME_HEIGHT)) ? W'(FRAME_HEIGHT) : bandhi;
    assign rx0 = axw[W-1] ? '0 : axw;
    assign rx1 = (axw + bxw > W'(FRAME_WIDTH)) ? W'(FRAME_WIDTH) : axw + bxw;
    assign ry0 = (ayw < topw) ? topw : ayw;
    assign ry1 = (ayw + byw > yhi) ? yhi : ayw + byw;

    assign inframe = !x_reg[W-1] && x_reg < W'(FRAME_WIDTH) && !y_reg[W-1]
                     && y_reg < W'(FRAME_HEIGHT);
    assign inband  = y_reg >= topw && y_reg < bandhi;
    assign pix_ok  = inframe && (inband || func_reg == fblr_pkg::FuncRead);
    assign step_minor = p_reg > 0;
    assign p_step = (step_minor ? p_reg - maj2_reg : p_reg) + m_reg;
    assign last_pix = (func_reg == fblr_pkg::FuncLine) ? (n_reg == 0)
                    : (func_reg == fblr_pkg::FuncRect)
                      ? (x_reg + 1 >= x1_reg && y_reg + 1 >= y1_reg) : 1'b1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            StClear: if (clr_reg == AW'(Depth - 1)) state_next = StIdle;
            StIdle:  if (start) state_next = StSetup;
            StSetup: state_next = skip_reg ? StDone : StAddr;
            StAddr:  state_next = StRead;
            StRead:  state_next = StWrite;
            StWrite: state_next = last_pix ? StDone : StAddr;
            StDone:  state_next = StIdle;
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == StClear)
        begin
            mem[clr_reg] <= 8'h00;
        end
        else if (state_reg == StWrite && hit_reg && func_reg != fblr_pkg::FuncRead)
        begin
            if (x_reg[0])
            begin
                mem[addr_reg] <= {rdata_reg[7:4], col_reg};
            end
            else
            begin
                mem[addr_reg] <= {col_reg, rdata_reg[3:0]};
            end
        end
        rdata_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StClear;
            clr_reg   <= '0;
            top_reg   <= '0;
            hgt_reg   <= 8'd240;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= state_reg == StDone;
            if (state_reg == StClear) clr_reg <= clr_reg + 1'b1;
            if (cfg_we)
            begin
                if (cfg_index == fblr_pkg::RegBandTop) top_reg <= cfg_data;
                else hgt_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            StIdle:
            begin
                func_reg <= func;
                col_reg  <= color;
                rc_reg   <= '0;
                sx_reg   <= dx[W-1];
                sy_reg   <= dy[W-1];
                xmaj_reg <= adx > ady;
                x1_reg   <= rx1;
                y1_reg   <= ry1;
                if (func == fblr_pkg::FuncRect)
                begin
                    x_reg <= rx0;
                    x0_reg <= rx0;
                    y_reg <= ry0;
                    skip_reg <= bx[fblr_pkg::CoordW-1] || bx == 0 || by[fblr_pkg::CoordW-1]
                                || by == 0 || rx0 >= rx1 || ry0 >= ry1;
                end
                else
                begin
                    x_reg <= axw;
                    x0_reg <= axw;
                    y_reg <= ayw;
                    skip_reg <= 1'b0;
                end
                if (adx > ady)
                begin
                    m_reg <= ady <<< 1;
                    p_reg <= (ady <<< 1) - adx;
                    maj2_reg <= adx <<< 1;
                    n_reg <= adx;
                end
                else
                begin
                    m_reg <= adx <<< 1;
                    p_reg <= (adx <<< 1) - ady;
                    maj2_reg <= ady <<< 1;
                    n_reg <= ady;
                end
            end
            StAddr:
            begin
                hit_reg  <= pix_ok;
                addr_reg <= AW'(AW'(y_reg) * AW'(RowBytes)) + AW'(x_reg[W-1:1]);
            end
            StWrite:
            begin
                if (func_reg == fblr_pkg::FuncRead && hit_reg)
                begin
                    rc_reg <= x_reg[0] ? rdata_reg[3:0] : rdata_reg[7:4];
                end
                if (func_reg == fblr_pkg::FuncLine)
                begin
                    n_reg <= n_reg - One;
                    p_reg <= p_step;
                    if (xmaj_reg)
                    begin
                        x_reg <= sx_reg ? x_reg - One : x_reg + One;
                        if (step_minor) y_reg <= sy_reg ? y_reg - One : y_reg + One;
                    end
                    else
                    begin
                        y_reg <= sy_reg ? y_reg - One : y_reg + One;
                        if (step_minor) x_reg <= sx_reg ? x_reg - One : x_reg + One;
                    end
                end
                else if (func_reg == fblr_pkg::FuncRect)
                begin
                    if (x_reg + 1 >= x1_reg)
                    begin
                        x_reg <= x0_reg;
                        y_reg <= y_reg + One;
                    end
                    else
                    begin
                        x_reg <= x_reg + One;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign busy = state_reg != StIdle;
    assign done = done_reg;
    assign read_color = done_reg ? rc_reg : '0;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("done held");
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == StIdle) else $error("done not idle");
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == StIdle |=> state_reg == StIdle || state_reg == StSetup)
        else $error("bad idle exit");
endmodule

/* dv/framebuffer_line_rect_plotter_tb.sv */
// Testbench: framebuffer_line_rect_plotter driven with directed and random commands,
// checked against a pixel-level predictor of the frame store.
`timescale 1ns / 100ps

module framebuffer_line_rect_plotter_tb;
    localparam int FrameW = fblr_pkg::DefFrameWidth;
    localparam int FrameH = fblr_pkg::DefFrameHeight;
    localparam int CoordBits = fblr_pkg::CoordW;
    localparam int ColorBits = fblr_pkg::ColorW;
    localparam int CfgBits   = fblr_pkg::CfgW;
    localparam longint CycleLimit = 6000000;

    typedef struct packed {
        logic [1:0]                  func;
        logic signed [CoordBits-1:0] ax;
        logic signed [CoordBits-1:0] ay;
        logic signed [CoordBits-1:0] bx;
        logic signed [CoordBits-1:0] by;
        logic [ColorBits-1:0]        color;
    } plot_req_t;

    class plot_scoreboard;
        logic [ColorBits-1:0] pix [FrameH][FrameW];
        int band_lo;
        int band_n;
        logic [ColorBits-1:0] color_q [$];
        int errors;

        function new();
            foreach (pix[y, x]) pix[y][x] = '0;
            band_lo = 0;
            band_n  = 240;
            errors  = 0;
        endfunction

        function bit drawable(int x, int y);
            return x >= 0 && x < FrameW && y >= band_lo && y < band_lo + band_n && y < FrameH;
        endfunction

        function void put(int x, int y, logic [ColorBits-1:0] c);
            if (drawable(x, y)) pix[y][x] = c;
        endfunction

        function void draw_line(int x, int y, int x2, int y2, logic [ColorBits-1:0] c);
            int dx, dy, sx, sy, m, p, twomaj;
            dx = x2 - x;
            dy = y2 - y;
            sx = (dx < 0) ? -1 : 1;
            sy = (dy < 0) ? -1 : 1;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dx > dy)
            begin
                m = 2 * dy; p = m - dx; twomaj = 2 * dx;
                for (int n = 0; n <= dx; n++)
                begin
                    put(x, y, c);
                    if (p > 0)
                    begin
                        y += sy;
                        p -= twomaj;
                    end
                    p += m;
                    x += sx;
                end
            end
            else
            begin
                m = 2 * dx; p = m - dy; twomaj = 2 * dy;
                for (int n = 0; n <= dy; n++)
                begin
                    put(x, y, c);
                    if (p > 0)
                    begin
                        x += sx;
                        p -= twomaj;
                    end
                    p += m;
                    y += sy;
                end
            end
        endfunction

        function void fill_rect(int x, int y, int w, int h, logic [ColorBits-1:0] c);
            int x0, x1, y0, y1, hi;
            if (w <= 0 || h <= 0) return;
            x0 = (x < 0) ? 0 : x;
            x1 = (x + w > FrameW) ? FrameW : x + w;
            hi = (band_lo + band_n > FrameH) ? FrameH : band_lo + band_n;
            y0 = (y < band_lo) ? band_lo : y;
            y1 = (y + h > hi) ? hi : y + h;
            for (int j = y0; j < y1; j++)
                for (int i = x0; i < x1; i++)
                    put(i, j, c);
        endfunction

        function void note(plot_req_t r);
            int ax, ay;
            logic [ColorBits-1:0] res;
            ax = int'(r.ax);
            ay = int'(r.ay);
            res = '0;
            case (r.func)
                fblr_pkg::FuncPlot: put(ax, ay, r.color);
                fblr_pkg::FuncLine: draw_line(ax, ay, int'(r.bx), int'(r.by), r.color);
                fblr_pkg::FuncRect: fill_rect(ax, ay, int'(r.bx), int'(r.by), r.color);
                default:
                    if (ax >= 0 && ax < FrameW && ay >= 0 && ay < FrameH) res = pix[ay][ax];
            endcase
            color_q.push_back(res);
        endfunction

        function void check(logic [ColorBits-1:0] got);
            logic [ColorBits-1:0] want;
            if (color_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result read_color=%0d", got);
                return;
            end
            want = color_q.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10) $display("read_color mismatch: expected %0d got %0d", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    logic cfg_we;
    logic cfg_index;
    logic [CfgBits-1:0] cfg_data;
    logic [1:0] func;
    logic signed [CoordBits-1:0] ax, ay, bx, by;
    logic [ColorBits-1:0] color;
    logic [ColorBits-1:0] read_color;

    plot_scoreboard sb = new();
    longint cycles = 0;

    framebuffer_line_rect_plotter DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .func(func), .ax(ax), .ay(ay), .bx(bx), .by(by), .color(color),
        .read_color(read_color)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done) sb.check(read_color);
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // leaves start high; caller lowers it or presents the next request
    task automatic send(plot_req_t r, int gap_pct);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
        func  <= r.func;
        ax    <= r.ax;
        ay    <= r.ay;
        bx    <= r.bx;
        by    <= r.by;
        color <= r.color;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        sb.note(r);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.color_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_band(int top, int height);
        cfg_we    <= 1'b1;
        cfg_index <= fblr_pkg::RegBandTop;
        cfg_data  <= top[CfgBits-1:0];
        @(posedge clk);
        cfg_index <= fblr_pkg::RegBandHeight;
        cfg_data  <= height[CfgBits-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.band_lo = top & 8'hFF;
        sb.band_n  = height & 8'hFF;
        @(posedge clk);
    endtask

    function automatic plot_req_t mk(logic [1:0] f, int x, int y, int x2, int y2, int c);
        plot_req_t r;
        r.func = f;
        r.ax = CoordBits'(x);
        r.ay = CoordBits'(y);
        r.bx = CoordBits'(x2);
        r.by = CoordBits'(y2);
        r.color = ColorBits'(c);
        return r;
    endfunction

    function automatic plot_req_t rand_req();
        plot_req_t r;
        int x, y;
        r.func  = 2'($urandom_range(3));
        r.color = ColorBits'($urandom_range(15));
        x = ($urandom_range(99) < 15) ? int'($urandom) : int'($urandom_range(360)) - 20;
        y = ($urandom_range(99) < 15) ? int'($urandom) : int'($urandom_range(280)) - 20;
        r.ax = CoordBits'(x);
        r.ay = CoordBits'(y);
        case (r.func)
            fblr_pkg::FuncLine:
                if ($urandom_range(99) < 15)
                begin
                    r.bx = CoordBits'($urandom);
                    r.by = CoordBits'($urandom);
                end
                else
                begin
                    r.bx = CoordBits'(int'(r.ax) + int'($urandom_range(80)) - 40);
                    r.by = CoordBits'(int'(r.ay) + int'($urandom_range(80)) - 40);
                end
            fblr_pkg::FuncRect:
                if ($urandom_range(199) == 0)
                begin
                    r.bx = CoordBits'($urandom);
                    r.by = CoordBits'($urandom);
                end
                else
                begin
                    r.bx = CoordBits'(int'($urandom_range(30)) - 4);
                    r.by = CoordBits'(int'($urandom_range(30)) - 4);
                end
            default:
            begin
                r.bx = CoordBits'($urandom);
                r.by = CoordBits'($urandom);
            end
        endcase
        return r;
    endfunction

    initial
    begin
        int tops [6]    = '{0, 239, 100, 50, 0, 200};
        int heights [6] = '{240, 240, 0, 30, 1, 255};
        int gaps [6]    = '{0, 45, 14, 0, 45, 14};
        plot_req_t dir [$];

        rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_index = fblr_pkg::RegBandTop;
        cfg_data = '0;
        func = fblr_pkg::FuncPlot; ax = '0; ay = '0; bx = '0; by = '0; color = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        set_band(0, 240);
        dir.push_back(mk(fblr_pkg::FuncRead, 5, 5, 0, 0, 0));
        dir.push_back(mk(fblr_pkg::FuncPlot, 0, 0, 0, 0, 15));
        dir.push_back(mk(fblr_pkg::FuncPlot, 1, 0, 0, 0, 9));
        dir.push_back(mk(fblr_pkg::FuncPlot, 319, 239, 0, 0, 7));
        dir.push_back(mk(fblr_pkg::FuncPlot, -1, 5, 0, 0, 3));
        dir.push_back(mk(fblr_pkg::FuncPlot, 320, 5, 0, 0, 3));
        dir.push_back(mk(fblr_pkg::FuncRead, 0, 0, 0, 0, 0));
        dir.push_back(mk(fblr_pkg::FuncRead, 1, 0, 0, 0, 0));
        dir.push_back(mk(fblr_pkg::FuncRead, 319, 239, 0, 0, 0));
        dir.push_back(mk(fblr_pkg::FuncRead, -2048, -2048, 0, 0, 0));
        dir.push_back(mk(fblr_pkg::FuncRead, 2047, 2047, 0, 0, 0));
        dir.push_back(mk(fblr_pkg::FuncLine, 10, 10, 60, 25, 4));
        dir.push_back(mk(fblr_pkg::FuncLine, 60, 90, 40, 20, 5));
        dir.push_back(mk(fblr_pkg::FuncLine, 100, 100, 70, 70, 6));
        dir.push_back(mk(fblr_pkg::FuncLine, 30, 30, 30, 30, 2));
        dir.push_back(mk(fblr_pkg::FuncLine, -2048, 2047, 2047, -2048, 11));
        dir.push_back(mk(fblr_pkg::FuncRead, 130, 100, 0, 0, 0));
        dir.push_back(mk(fblr_pkg::FuncRect, 200, 50, 0, 10, 8));
        dir.push_back(mk(fblr_pkg::FuncRect, 200, 50, 10, -3, 8));
        dir.push_back(mk(fblr_pkg::FuncRect, -5, -5, 12, 9, 13));
        dir.push_back(mk(fblr_pkg::FuncRect, 310, 230, 20, 20, 12));
        dir.push_back(mk(fblr_pkg::FuncRect, -2048, -2048, 2047, 2047, 1));
        dir.push_back(mk(fblr_pkg::FuncRead, 160, 120, 0, 0, 0));
        foreach (dir[i]) send(dir[i], 0);
        drain();

        foreach (tops[p])
        begin
            set_band(tops[p], heights[p]);
            for (int i = 0; i < 152; i++) send(rand_req(), gaps[p]);
            drain();
        end

        if (sb.color_q.size() != 0) sb.errors += sb.color_q.size();
        if (sb.errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
